// ===== hdl/box_iou_pair_core_macros.svh =====
// ----------------------------------------------------------------------------
// Box IoU pair core assertion macros
// Shared concurrent assertion wrappers for the box IoU pair core.
// ----------------------------------------------------------------------------
`ifndef BOX_IOU_PAIR_CORE_MACROS_SVH
`define BOX_IOU_PAIR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define BIOU_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("box_iou_pair_core: assertion failed");

`define BIOU_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("box_iou_pair_core: forbidden condition seen");

`else

`define BIOU_ASSERT(lbl, ck, rn, prop)

`define BIOU_ASSERT_NEVER(lbl, ck, rn, cond)

`endif

`endif

// ===== hdl/biou_pkg.sv =====
// ----------------------------------------------------------------------------
// Box IoU pair package
// Fixed constants and status types shared by the box IoU pair pipeline.
// ----------------------------------------------------------------------------
package biou_pkg;

	localparam int EPS_WIDTH = 8;

	typedef struct packed {
		logic nov;
		logic bad;
		logic sat;
	} biou_flags_t;

endpackage

// ===== hdl/biou_geom.sv =====
// ----------------------------------------------------------------------------
// Box IoU pair geometry stages
// Overlap extents, widened box extents and the three area products.
// ----------------------------------------------------------------------------
module biou_geom import biou_pkg::*; #(
	parameter int CW = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [EPS_WIDTH-1:0]           eps,
	input  logic signed [CW-1:0]           box_x1,
	input  logic signed [CW-1:0]           box_y1,
	input  logic signed [CW-1:0]           box_x2,
	input  logic signed [CW-1:0]           box_y2,
	input  logic signed [CW-1:0]           query_x1,
	input  logic signed [CW-1:0]           query_y1,
	input  logic signed [CW-1:0]           query_x2,
	input  logic signed [CW-1:0]           query_y2,
	output logic                           v_s2,
	output logic                           nov_s2,
	output logic signed [2*(CW+2)-1:0]     inter_s2,
	output logic signed [2*(CW+2)-1:0]     area_b_s2,
	output logic signed [2*(CW+2)-1:0]     area_q_s2
);

	localparam int DW = CW + 2;
	localparam int PW = 2 * DW;

	logic signed [CW:0]   eps_c;
	logic signed [DW-1:0] eps_d;
	logic signed [CW:0]   qx1_e;
	logic signed [CW:0]   qy1_e;
	logic signed [CW:0]   lo_x;
	logic signed [CW:0]   lo_y;
	logic signed [CW-1:0] hi_x;
	logic signed [CW-1:0] hi_y;

	logic                 v_s1;
	logic signed [DW-1:0] iw_s1;
	logic signed [DW-1:0] ih_s1;
	logic signed [DW-1:0] dxb_s1;
	logic signed [DW-1:0] dyb_s1;
	logic signed [DW-1:0] dxq_s1;
	logic signed [DW-1:0] dyq_s1;

	logic signed [PW-1:0] inter_p;
	logic signed [PW-1:0] area_b_p;
	logic signed [PW-1:0] area_q_p;

	assign eps_c = $signed((CW+1)'(eps));
	assign eps_d = $signed(DW'(eps));
	assign qx1_e = (CW+1)'(query_x1) + eps_c;
	assign qy1_e = (CW+1)'(query_y1) + eps_c;

	always_comb begin
		lo_x = ((CW+1)'(box_x1) > qx1_e) ? (CW+1)'(box_x1) : qx1_e;
		lo_y = ((CW+1)'(box_y1) > qy1_e) ? (CW+1)'(box_y1) : qy1_e;
		hi_x = (box_x2 < query_x2) ? box_x2 : query_x2;
		hi_y = (box_y2 < query_y2) ? box_y2 : query_y2;
	end

	assign inter_p  = iw_s1 * ih_s1;
	assign area_b_p = dxb_s1 * dyb_s1;
	assign area_q_p = dxq_s1 * dyq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		iw_s1     <= DW'(hi_x) - DW'(lo_x);
		ih_s1     <= DW'(hi_y) - DW'(lo_y);
		dxb_s1    <= DW'(box_x2) - DW'(box_x1) + eps_d;
		dyb_s1    <= DW'(box_y2) - DW'(box_y1) + eps_d;
		dxq_s1    <= DW'(query_x2) - DW'(query_x1) + eps_d;
		dyq_s1    <= DW'(query_y2) - DW'(query_y1) + eps_d;
		nov_s2    <= iw_s1[DW-1] || (iw_s1 == '0) || ih_s1[DW-1] || (ih_s1 == '0);
		inter_s2  <= inter_p;
		area_b_s2 <= area_b_p;
		area_q_s2 <= area_q_p;
	end

endmodule

// ===== hdl/biou_union.sv =====
// ----------------------------------------------------------------------------
// Box IoU pair union stages
// Union area, its sign check and the saturation compare.
// ----------------------------------------------------------------------------
module biou_union import biou_pkg::*; #(
	parameter int PW = 36
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   v_in,
	input  logic                   nov_in,
	input  logic signed [PW-1:0]   inter_in,
	input  logic signed [PW-1:0]   area_b_in,
	input  logic signed [PW-1:0]   area_q_in,
	output logic                   v_s5,
	output biou_flags_t            flags_s5,
	output logic [PW+1:0]          rem_s5,
	output logic [PW+1:0]          div_s5
);

	localparam int UW = PW + 2;

	logic                 v_s3;
	logic                 v_s4;
	logic                 nov_s3;
	logic                 nov_s4;
	logic signed [PW:0]   sum_s3;
	logic signed [PW-1:0] inter_s3;
	logic signed [UW-1:0] ua_s4;
	logic signed [UW-1:0] inter_s4;
	logic                 bad;

	assign bad = ua_s4[UW-1] || (ua_s4 == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s3 <= v_in;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3       <= (PW+1)'(area_b_in) + (PW+1)'(area_q_in);
		inter_s3     <= inter_in;
		nov_s3       <= nov_in;
		ua_s4        <= UW'(sum_s3) - UW'(inter_s3);
		inter_s4     <= UW'(inter_s3);
		nov_s4       <= nov_s3;
		flags_s5.nov <= nov_s4;
		flags_s5.bad <= bad;
		flags_s5.sat <= !bad && (inter_s4 >= ua_s4);
		rem_s5       <= inter_s4;
		div_s5       <= ua_s4;
	end

endmodule

// ===== hdl/biou_div.sv =====
// ----------------------------------------------------------------------------
// Box IoU pair divider
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`include "box_iou_pair_core_macros.svh"

module biou_div import biou_pkg::*; #(
	parameter int UW = 38,
	parameter int RW = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           v_in,
	input  biou_flags_t    flags_in,
	input  logic [UW-1:0]  rem_in,
	input  logic [UW-1:0]  div_in,
	output logic           v_out,
	output biou_flags_t    flags_out,
	output logic [RW-1:0]  quo_out
);

	logic          v_s     [0:RW];
	biou_flags_t   flags_s [0:RW];
	logic [UW-1:0] rem_s   [0:RW];
	logic [UW-1:0] div_s   [0:RW];
	logic [RW-1:0] quo_s   [0:RW];

	assign v_s[0]     = v_in;
	assign flags_s[0] = flags_in;
	assign rem_s[0]   = rem_in;
	assign div_s[0]   = div_in;
	assign quo_s[0]   = '0;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [UW:0] shl;
		logic [UW:0] dif;
		logic        take;

		assign shl  = {rem_s[k], 1'b0};
		assign dif  = shl - {1'b0, div_s[k]};
		assign take = !dif[UW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			flags_s[k+1] <= flags_s[k];
			div_s[k+1]   <= div_s[k];
			rem_s[k+1]   <= take ? dif[UW-1:0] : shl[UW-1:0];
			quo_s[k+1]   <= {quo_s[k][RW-2:0], take};
		end
	end

	assign v_out     = v_s[RW];
	assign flags_out = flags_s[RW];
	assign quo_out   = quo_s[RW];

	`BIOU_ASSERT(a_rem_below_div, clk, arst_n, v_s[RW] && !flags_s[RW].nov && !flags_s[RW].bad && !flags_s[RW].sat |-> rem_s[RW] < div_s[RW])
	`BIOU_ASSERT(a_valid_travels, clk, arst_n, v_in |-> ##RW v_out)

endmodule

// ===== hdl/box_iou_pair_core.sv =====
// ----------------------------------------------------------------------------
// Box IoU pair core
// Intersection over union of one axis-aligned box pair per clock.
// ----------------------------------------------------------------------------
// A pair of boxes (box and query, low and high corners, signed, 4 fraction
// bits) is taken at a rising edge with start high; busy is always low, so a
// new pair may follow in every cycle. The eps widening register is written
// through cfg_we / cfg_wdata; the user must write it only while no pair is
// in flight, as the block itself does not enforce this. Each pair gives one
// word on overlap and bad_union, marked by a one-cycle done strobe.
// Throughput is one pair per cycle: the pipeline is five geometry, area and
// union stages, one restoring divider stage per quotient bit, and an output
// register.
// No overlap gives 0, bad_union clear; a non-positive union gives 0 with
// bad_union set; a ratio of one or more saturates overlap to all ones.
// Reset empties the pipeline and clears eps to 0. The receiver cannot stall:
// a word is on the outputs for exactly the cycle that done is high.
// ----------------------------------------------------------------------------
`include "box_iou_pair_core_macros.svh"

module box_iou_pair_core import biou_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int RATIO_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [EPS_WIDTH-1:0]          cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] box_x1,
	input  logic signed [COORD_WIDTH-1:0] box_y1,
	input  logic signed [COORD_WIDTH-1:0] box_x2,
	input  logic signed [COORD_WIDTH-1:0] box_y2,
	input  logic signed [COORD_WIDTH-1:0] query_x1,
	input  logic signed [COORD_WIDTH-1:0] query_y1,
	input  logic signed [COORD_WIDTH-1:0] query_x2,
	input  logic signed [COORD_WIDTH-1:0] query_y2,
	output logic                          done,
	output logic [RATIO_WIDTH-1:0]        overlap,
	output logic                          bad_union
);

	localparam int DW  = COORD_WIDTH + 2;
	localparam int PW  = 2 * DW;
	localparam int UW  = PW + 2;
	localparam int LAT = RATIO_WIDTH + 6;

	logic [EPS_WIDTH-1:0]  eps_q;

	logic                  g_v;
	logic                  g_nov;
	logic signed [PW-1:0]  g_inter;
	logic signed [PW-1:0]  g_area_b;
	logic signed [PW-1:0]  g_area_q;

	logic                  u_v;
	biou_flags_t           u_flags;
	logic [UW-1:0]         u_rem;
	logic [UW-1:0]         u_dvsr;

	logic                  d_v;
	biou_flags_t           d_flags;
	logic [RATIO_WIDTH-1:0] d_quo;

	logic                  done_q;
	logic [RATIO_WIDTH-1:0] overlap_q;
	logic                  bad_union_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	biou_geom #(
		.CW (COORD_WIDTH)
	) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.eps       (eps_q),
		.box_x1    (box_x1),
		.box_y1    (box_y1),
		.box_x2    (box_x2),
		.box_y2    (box_y2),
		.query_x1  (query_x1),
		.query_y1  (query_y1),
		.query_x2  (query_x2),
		.query_y2  (query_y2),
		.v_s2      (g_v),
		.nov_s2    (g_nov),
		.inter_s2  (g_inter),
		.area_b_s2 (g_area_b),
		.area_q_s2 (g_area_q)
	);

	biou_union #(
		.PW (PW)
	) u_union (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (g_v),
		.nov_in    (g_nov),
		.inter_in  (g_inter),
		.area_b_in (g_area_b),
		.area_q_in (g_area_q),
		.v_s5      (u_v),
		.flags_s5  (u_flags),
		.rem_s5    (u_rem),
		.div_s5    (u_dvsr)
	);

	biou_div #(
		.UW (UW),
		.RW (RATIO_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (u_v),
		.flags_in  (u_flags),
		.rem_in    (u_rem),
		.div_in    (u_dvsr),
		.v_out     (d_v),
		.flags_out (d_flags),
		.quo_out   (d_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d_v;
		end
	end

	always_ff @(posedge clk) begin
		bad_union_q <= d_flags.bad && !d_flags.nov;
		if (d_flags.nov || d_flags.bad) begin
			overlap_q <= '0;
		end else if (d_flags.sat) begin
			overlap_q <= '1;
		end else begin
			overlap_q <= d_quo;
		end
	end

	assign done      = done_q;
	assign overlap   = overlap_q;
	assign bad_union = bad_union_q;

	`BIOU_ASSERT(a_latency, clk, arst_n, start && !busy |-> ##LAT done)
	`BIOU_ASSERT(a_no_spurious, clk, arst_n, done |-> $past(start && !busy, LAT))
	`BIOU_ASSERT_NEVER(a_bad_forces_zero, clk, arst_n, done && bad_union && (overlap != '0))

endmodule

// ===== tb/sv/box_iou_pair_core_test.sv =====
// ----------------------------------------------------------------------------
// Box IoU pair core regression
// Feeds box pairs through the command port under several eps settings, with
// random gaps between start pulses in alternate phases, and checks every
// done word against a local integer model of IoU kept in step with eps.
// ----------------------------------------------------------------------------
module box_iou_pair_core_test import biou_pkg::*;;

	localparam int COORD_W = 16;
	localparam int RATIO_W = 16;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t box_x1;
		coord_t box_y1;
		coord_t box_x2;
		coord_t box_y2;
		coord_t query_x1;
		coord_t query_y1;
		coord_t query_x2;
		coord_t query_y2;
	} box_pair_t;

	typedef struct packed {
		logic [RATIO_W-1:0] overlap;
		logic               bad_union;
	} iou_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [EPS_WIDTH-1:0] cfg_wdata = '0;
	logic                 start = 1'b0;
	box_pair_t            cur_pair = '0;
	logic                 busy;
	logic                 done;
	logic [RATIO_W-1:0]   overlap;
	logic                 bad_union;

	box_pair_t            pair_q[$];
	iou_word_t            iou_expect_q[$];
	iou_word_t            want_word;
	logic [EPS_WIDTH-1:0] eps_now = '0;
	logic                 gaps_on = 1'b1;
	int                   gap_left = 0;
	int                   fail_cnt = 0;

	box_iou_pair_core #(
		.COORD_WIDTH(COORD_W),
		.RATIO_WIDTH(RATIO_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.start    (start),
		.busy     (busy),
		.box_x1   (cur_pair.box_x1),
		.box_y1   (cur_pair.box_y1),
		.box_x2   (cur_pair.box_x2),
		.box_y2   (cur_pair.box_y2),
		.query_x1 (cur_pair.query_x1),
		.query_y1 (cur_pair.query_y1),
		.query_x2 (cur_pair.query_x2),
		.query_y2 (cur_pair.query_y2),
		.done     (done),
		.overlap  (overlap),
		.bad_union(bad_union)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic iou_word_t iou_predict(box_pair_t p, logic [EPS_WIDTH-1:0] e);
		longint ev, bx1, by1, bx2, by2, qx1, qy1, qx2, qy2;
		longint iw, ih, inter, uni;
		iou_word_t w;
		w = '0;
		ev = e;
		bx1 = p.box_x1;
		by1 = p.box_y1;
		bx2 = p.box_x2;
		by2 = p.box_y2;
		qx1 = p.query_x1;
		qy1 = p.query_y1;
		qx2 = p.query_x2;
		qy2 = p.query_y2;
		iw = ((bx2 < qx2) ? bx2 : qx2) - ((bx1 > qx1 + ev) ? bx1 : qx1 + ev);
		ih = ((by2 < qy2) ? by2 : qy2) - ((by1 > qy1 + ev) ? by1 : qy1 + ev);
		if (iw <= 0 || ih <= 0)
			return w;
		inter = iw * ih;
		uni = (bx2 - bx1 + ev) * (by2 - by1 + ev) + (qx2 - qx1 + ev) * (qy2 - qy1 + ev)
			- inter;
		if (uni <= 0)
			w.bad_union = 1'b1;
		else if (inter >= uni)
			w.overlap = '1;
		else
			w.overlap = RATIO_W'((inter <<< RATIO_W) / uni);
		return w;
	endfunction

	function automatic box_pair_t pair_of(int bx1, int by1, int bx2, int by2,
			int qx1, int qy1, int qx2, int qy2);
		box_pair_t p;
		p.box_x1 = coord_t'(bx1);
		p.box_y1 = coord_t'(by1);
		p.box_x2 = coord_t'(bx2);
		p.box_y2 = coord_t'(by2);
		p.query_x1 = coord_t'(qx1);
		p.query_y1 = coord_t'(qy1);
		p.query_x2 = coord_t'(qx2);
		p.query_y2 = coord_t'(qy2);
		return p;
	endfunction

	function automatic coord_t clamp_coord(int v);
		if (v > 32767)
			return coord_t'(32767);
		if (v < -32768)
			return coord_t'(-32768);
		return coord_t'(v);
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int rand_extent();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return int'($urandom_range(1, 256));
		if (r < 95)
			return int'($urandom_range(257, 4096));
		return int'($urandom_range(4097, 65535));
	endfunction

	function automatic box_pair_t make_pair();
		box_pair_t p;
		int kind, w, h, bx, by, qx, qy;
		coord_t t;
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			p = {$urandom, $urandom, $urandom, $urandom};
			return p;
		end
		w = rand_extent();
		h = rand_extent();
		bx = rand_coord();
		by = rand_coord();
		p.box_x1 = clamp_coord(bx);
		p.box_y1 = clamp_coord(by);
		p.box_x2 = clamp_coord(bx + w);
		p.box_y2 = clamp_coord(by + h);
		if (kind < 25) begin
			p.query_x1 = p.box_x1;
			p.query_y1 = p.box_y1;
			p.query_x2 = p.box_x2;
			p.query_y2 = p.box_y2;
		end else begin
			qx = bx + int'($urandom_range(0, 2 * w)) - w;
			qy = by + int'($urandom_range(0, 2 * h)) - h;
			p.query_x1 = clamp_coord(qx);
			p.query_y1 = clamp_coord(qy);
			p.query_x2 = clamp_coord(qx + rand_extent());
			p.query_y2 = clamp_coord(qy + rand_extent());
		end
		if (kind >= 90) begin
			case ($urandom_range(0, 3))
				0: begin
					t = p.box_x1;
					p.box_x1 = p.box_x2;
					p.box_x2 = t;
				end
				1: begin
					t = p.box_y1;
					p.box_y1 = p.box_y2;
					p.box_y2 = t;
				end
				2: begin
					t = p.query_x1;
					p.query_x1 = p.query_x2;
					p.query_x2 = t;
				end
				default: begin
					t = p.query_y1;
					p.query_y1 = p.query_y2;
					p.query_y2 = t;
				end
			endcase
		end
		return p;
	endfunction

	function automatic int next_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 40));
	endfunction

	task automatic add_pair(input box_pair_t p);
		pair_q.insert(pair_q.size(), p);
	endtask

	task automatic add_expect(input iou_word_t w);
		iou_expect_q.insert(iou_expect_q.size(), w);
	endtask

	task automatic fill_random(input int n);
		repeat (n) add_pair(make_pair());
	endtask

	task automatic wait_idle();
		while (pair_q.size() != 0 || start || iou_expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_eps(input logic [EPS_WIDTH-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		eps_now = v;
		@(negedge clk);
	endtask

	// driver: hold while busy, drop start during gaps, advance on accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				add_expect(iou_predict(cur_pair, eps_now));
			if (!(start && busy)) begin
				if (gap_left != 0) begin
					start <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pair_q.size() != 0) begin
					start <= 1'b1;
					cur_pair <= pair_q.pop_front();
					gap_left <= next_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each done word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (iou_expect_q.size() == 0) begin
				$error("unexpected word: overlap %0d bad_union %0b", overlap, bad_union);
				fail_cnt++;
			end else begin
				want_word = iou_expect_q.pop_front();
				if (overlap !== want_word.overlap) begin
					$error("overlap: expected %0d, got %0d", want_word.overlap, overlap);
					fail_cnt++;
				end
				if (bad_union !== want_word.bad_union) begin
					$error("bad_union: expected %0b, got %0b", want_word.bad_union,
						bad_union);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		logic [EPS_WIDTH-1:0] eps_plan [6];
		eps_plan = '{8'd255, 8'd1, 8'd0, 8'd16, 8'd128, 8'd0};
		eps_plan[5] = EPS_WIDTH'($urandom_range(2, 254));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
		add_pair(pair_of(0, 0, 16, 16, 0, 0, 16, 16));
		add_pair(pair_of(0, 0, 32, 32, 16, 16, 48, 48));
		add_pair(pair_of(0, 0, 16, 16, 32, 0, 48, 16));
		add_pair(pair_of(0, 0, 16, 16, 0, 32, 16, 48));
		add_pair(pair_of(0, 0, 16, 16, 16, 0, 32, 16));
		add_pair(pair_of(-32768, -32768, 32767, 32767,
			-32768, -32768, 32767, 32767));
		add_pair(pair_of(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
		add_pair(pair_of(0, 0, 1, 1, -32768, -32768, 32767, 32767));
		add_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		add_pair(pair_of(-32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768));
		add_pair(pair_of(16, 16, 0, 0, 0, 0, 16, 16));
		add_pair(pair_of(0, 0, 16, 16, 16, 16, 0, 0));
		add_pair(pair_of(-32768, -32768, -32767, -32767,
			-32768, -32768, -32767, -32767));
		add_pair(pair_of(0, 0, 100, 3, 0, 0, 3, 100));
		add_pair(pair_of(-100, -100, 100, 100, -50, -50, 50, 50));
		fill_random(300);

		for (int ph = 0; ph < 6; ph++) begin
			write_eps(eps_plan[ph]);
			gaps_on = (ph % 2 == 0);
			if (ph == 0) begin
				add_pair(pair_of(0, 0, 16, 16, 0, 0, 16, 16));
				add_pair(pair_of(0, 0, 4096, 4096, 0, 0, 4096, 4096));
				add_pair(pair_of(-32768, -32768, 32767, 32767,
					-32768, -32768, 32767, 32767));
				add_pair(pair_of(0, 0, 300, 300, -255, -255, 300, 300));
				add_pair(pair_of(-32768, -32768, 32767, 32767,
					32767, 32767, 32767, 32767));
			end
			fill_random(270);
		end

		wait_idle();
		repeat (RATIO_W + 12) @(negedge clk);
		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#(12 * 500000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
